@@ src/io_wait_queue_release_assert.svh @@
// ----------------------------------------------------------------------------
// io_wait_queue_release_assert.svh
// assertion macros shared by the checker of the wait queue block
// ----------------------------------------------------------------------------
`ifndef IO_WAIT_QUEUE_RELEASE_ASSERT_SVH
`define IO_WAIT_QUEUE_RELEASE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define IWQR_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wait queue check failed");

// next-cycle implication, clocked on clock, off during reset
`define IWQR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wait queue check failed");

`endif

@@ src/iwqr_pkg.sv @@
// ----------------------------------------------------------------------------
// iwqr_pkg
// types and constants of the i/o wait queue release block
// ----------------------------------------------------------------------------
package iwqr_pkg;

   localparam int NUM_DEVICES     = 3;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_W            = 8;
   localparam int DEV_W           = 2;
   localparam int WAIT_W          = 8;
   localparam int ENTRY_W         = WAIT_W + ID_W;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 8;
   localparam int CMDQ_DEPTH      = 2;

   localparam logic [DEV_W-1:0] DEV_DISK    = 2'd0;
   localparam logic [DEV_W-1:0] DEV_TAPE    = 2'd1;
   localparam logic [DEV_W-1:0] DEV_PRINTER = 2'd2;
   localparam logic [DEV_W-1:0] DEV_INVALID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_WAIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPE_WAIT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRINTER_WAIT = 2'd2;

   localparam logic [WAIT_W-1:0] DISK_WAIT_RST    = 8'd1;
   localparam logic [WAIT_W-1:0] TAPE_WAIT_RST    = 8'd2;
   localparam logic [WAIT_W-1:0] PRINTER_WAIT_RST = 8'd3;

   typedef enum logic {
      CMD_BLOCK = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   // classified command as it travels from front to back
   typedef struct packed {
      cmd_type            cmd;
      logic [DEV_W-1:0]   dev;
      logic [ID_W-1:0]    pid;
      logic [WAIT_W-1:0]  wait_cnt;
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]   released_id;
      logic [DEV_W-1:0]  from_device;
      logic              to_low_priority;
      logic              dropped;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_FLUSH
   } back_state_type;

endpackage

@@ src/iwqr_ram.sv @@
// ----------------------------------------------------------------------------
// iwqr_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module iwqr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/iwqr_front.sv @@
// ----------------------------------------------------------------------------
// iwqr_front
// wait count registers, command acceptance and classification
// ----------------------------------------------------------------------------
module iwqr_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               q_full,
   input  logic                               req_cmd,
   input  logic [iwqr_pkg::DEV_W-1:0]         req_device,
   input  logic [iwqr_pkg::ID_W-1:0]          req_process_id,
   input  logic                               csr_we,
   input  logic [iwqr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iwqr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                               push,
   output iwqr_pkg::op_type                   op
);
   import iwqr_pkg::*;

   logic [WAIT_W-1:0] disk_wait_ff, disk_wait_in;
   logic [WAIT_W-1:0] tape_wait_ff, tape_wait_in;
   logic [WAIT_W-1:0] prn_wait_ff,  prn_wait_in;
   logic [WAIT_W-1:0] sel_wait;
   cmd_type           cmd;

   always_comb begin
      disk_wait_in = disk_wait_ff;
      tape_wait_in = tape_wait_ff;
      prn_wait_in  = prn_wait_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DISK_WAIT:    disk_wait_in = csr_wdata[WAIT_W-1:0];
            CSR_TAPE_WAIT:    tape_wait_in = csr_wdata[WAIT_W-1:0];
            CSR_PRINTER_WAIT: prn_wait_in  = csr_wdata[WAIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_wait_ff <= DISK_WAIT_RST;
         tape_wait_ff <= TAPE_WAIT_RST;
         prn_wait_ff  <= PRINTER_WAIT_RST;
      end else begin
         disk_wait_ff <= disk_wait_in;
         tape_wait_ff <= tape_wait_in;
         prn_wait_ff  <= prn_wait_in;
      end
   end

   // wait count snapshot for the named device
   always_comb begin
      unique case (req_device)
         DEV_DISK:    sel_wait = disk_wait_ff;
         DEV_TAPE:    sel_wait = tape_wait_ff;
         DEV_PRINTER: sel_wait = prn_wait_ff;
         default:     sel_wait = '0;
      endcase
   end

   assign cmd = cmd_type'(req_cmd);

   // invalid device blocks are taken and dropped here
   assign push = start && !q_full && (cmd == CMD_TICK || req_device != DEV_INVALID);

   always_comb begin
      op.cmd      = cmd;
      op.dev      = (cmd == CMD_TICK) ? DEV_DISK : req_device;
      op.pid      = req_process_id;
      op.wait_cnt = sel_wait;
   end

endmodule

@@ src/iwqr_cmdq.sv @@
// ----------------------------------------------------------------------------
// iwqr_cmdq
// short command queue between front and back
// ----------------------------------------------------------------------------
module iwqr_cmdq #(
   parameter int DEPTH = iwqr_pkg::CMDQ_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iwqr_pkg::op_type  push_op,
   input  logic              pop,
   output logic              full,
   output logic              valid,
   output iwqr_pkg::op_type  head_op
);
   import iwqr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head_op = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ src/iwqr_back.sv @@
// ----------------------------------------------------------------------------
// iwqr_back
// executes block and tick commands on the three device rings in memory
// ----------------------------------------------------------------------------
module iwqr_back #(
   parameter int QUEUE_DEPTH = iwqr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  iwqr_pkg::op_type  q_op,
   output logic              q_pop,
   output logic              rsp_valid,
   output iwqr_pkg::rsp_type rsp
);
   import iwqr_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int TOTAL = NUM_DEVICES * QUEUE_DEPTH;
   localparam int AW    = $clog2(TOTAL);

   back_state_type    state_ff, state_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [IDX_W-1:0]  head_ff [NUM_DEVICES];
   logic [IDX_W-1:0]  head_in [NUM_DEVICES];
   logic [IDX_W-1:0]  tail_ff [NUM_DEVICES];
   logic [IDX_W-1:0]  tail_in [NUM_DEVICES];
   logic [CNT_W-1:0]  cnt_ff  [NUM_DEVICES];
   logic [CNT_W-1:0]  cnt_in  [NUM_DEVICES];
   logic              ovf_ff, ovf_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [DEV_W-1:0]   cur_dev;
   logic [IDX_W-1:0]   cur_head, cur_tail;
   logic [CNT_W-1:0]   cur_cnt;
   logic               cur_empty, cur_full, dev_is_last;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
   logic [WAIT_W-1:0]  head_wait, wait_dec;
   logic [ID_W-1:0]    head_pid;
   logic               release_now;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
      ring_next = (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
   endfunction

   function automatic logic [AW-1:0] slot_addr(input logic [DEV_W-1:0] d,
                                               input logic [IDX_W-1:0] i);
      slot_addr = AW'(d) * AW'(QUEUE_DEPTH) + AW'(i);
   endfunction

   iwqr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // idle looks at the queued command, the scan at its own device counter
   assign cur_dev     = (state_ff == ST_IDLE) ? q_op.dev : dev_ff;
   assign cur_head    = head_ff[cur_dev];
   assign cur_tail    = tail_ff[cur_dev];
   assign cur_cnt     = cnt_ff[cur_dev];
   assign cur_empty   = (cur_cnt == '0);
   assign cur_full    = (cur_cnt == CNT_W'(QUEUE_DEPTH));
   assign dev_is_last = (dev_ff == DEV_PRINTER);

   // head entry count-down
   assign head_wait   = mem_rdata[ENTRY_W-1:ID_W];
   assign head_pid    = mem_rdata[ID_W-1:0];
   assign wait_dec    = (head_wait != '0) ? head_wait - WAIT_W'(1) : '0;
   assign release_now = (wait_dec == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_op.cmd == CMD_TICK) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!cur_empty) begin
               state_in = ST_UPDATE;
            end else if (dev_is_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_UPDATE: state_in = dev_is_last ? ST_FLUSH : ST_READ;
         ST_FLUSH:  state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      dev_in        = dev_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot_addr(cur_dev, cur_tail);
      mem_wdata     = {q_op.wait_cnt, q_op.pid};
      mem_re        = 1'b0;
      mem_raddr     = slot_addr(cur_dev, cur_head);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_op.cmd == CMD_TICK) begin
                  dev_in = DEV_DISK;
               end else if (cur_full) begin
                  ovf_in = 1'b1;
               end else begin
                  mem_we           = 1'b1;
                  tail_in[cur_dev] = ring_next(cur_tail);
                  cnt_in[cur_dev]  = cur_cnt + CNT_W'(1);
               end
            end
         end
         ST_READ: begin
            mem_re = !cur_empty;
            if (cur_empty && !dev_is_last) begin
               dev_in = dev_ff + DEV_W'(1);
            end
         end
         ST_UPDATE: begin
            if (release_now) begin
               head_in[cur_dev] = ring_next(cur_head);
               cnt_in[cur_dev]  = cur_cnt - CNT_W'(1);
               // the held release is not the last one: send it now
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = pend_ff;
               end
               pend_valid_in           = 1'b1;
               pend_in.released_id     = head_pid;
               pend_in.from_device     = dev_ff;
               pend_in.to_low_priority = (dev_ff == DEV_DISK);
               pend_in.dropped         = ovf_ff;
               pend_in.last            = 1'b0;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = slot_addr(cur_dev, cur_head);
               mem_wdata = {wait_dec, head_pid};
            end
            if (!dev_is_last) begin
               dev_in = dev_ff + DEV_W'(1);
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               rsp_in.last  = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dev_ff        <= DEV_DISK;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int d = 0; d < NUM_DEVICES; d++) begin
            head_ff[d] <= '0;
            tail_ff[d] <= '0;
            cnt_ff[d]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         dev_ff        <= dev_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ src/io_wait_queue_release.sv @@
// ----------------------------------------------------------------------------
// io_wait_queue_release
// three fifo wait queues (disk, tape, printer) released by time ticks
// ----------------------------------------------------------------------------
//
//   channel  ports                          transfer
//   -------  -----------------------------  ----------------------------------
//   request  start, busy, req_*             edge with start high, busy low
//   result   rsp_valid, rsp_*               edge ending each rsp_valid cycle
//   config   csr_we, csr_index, csr_wdata   edge with csr_we high
//
// - a block command is done in the idle state; a tick dequeues, then visits
//   each device in turn (memory read of its head entry if non-empty, then
//   count-down and write-back), and ends by sending the final release
// - the back end runs through the single-port-read entry memory, one device
//   at a time, so a tick's cost follows that memory's read latency
// - a two-entry command queue lets the front take new requests while the
//   back end scans; busy is high only when that queue is full
// - results cannot be held off; each is valid for exactly one cycle
// - reset is synchronous and clears the ring pointers, counts and the drop flag,
//   and loads the wait registers with their defaults; entry memory is not cleared
//
module io_wait_queue_release #(
   parameter int QUEUE_DEPTH = iwqr_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_cmd,
   input  logic [iwqr_pkg::DEV_W-1:0]       req_device,
   input  logic [iwqr_pkg::ID_W-1:0]        req_process_id,
   // result channel
   output logic                             rsp_valid,
   output logic [iwqr_pkg::ID_W-1:0]        rsp_released_id,
   output logic [iwqr_pkg::DEV_W-1:0]       rsp_from_device,
   output logic                             rsp_to_low_priority,
   output logic                             rsp_dropped,
   output logic                             rsp_last,
   // configuration write port
   input  logic                             csr_we,
   input  logic [iwqr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [iwqr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import iwqr_pkg::*;

   logic    q_full, q_valid, q_pop, push;
   op_type  push_op, q_op;
   rsp_type rsp;

   // front: wait registers, accept and classify
   iwqr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .q_full         (q_full),
      .req_cmd        (req_cmd),
      .req_device     (req_device),
      .req_process_id (req_process_id),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .push           (push),
      .op             (push_op)
   );

   // decoupling queue
   iwqr_cmdq #(
      .DEPTH (CMDQ_DEPTH)
   ) u_cmdq (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (q_pop),
      .full    (q_full),
      .valid   (q_valid),
      .head_op (q_op)
   );

   // back: ring bookkeeping, entry memory and release sequencing
   iwqr_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   // a request is held off only while the command queue is full
   assign busy = q_full;

   assign rsp_released_id     = rsp.released_id;
   assign rsp_from_device     = rsp.from_device;
   assign rsp_to_low_priority = rsp.to_low_priority;
   assign rsp_dropped         = rsp.dropped;
   assign rsp_last            = rsp.last;

endmodule

@@ src/iwqr_checker.sv @@
// ----------------------------------------------------------------------------
// iwqr_checker
// port-level checks on the release stream of the wait queue block
// ----------------------------------------------------------------------------
`include "io_wait_queue_release_assert.svh"

module iwqr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic [iwqr_pkg::DEV_W-1:0]  rsp_from_device,
   input logic                        rsp_to_low_priority,
   input logic                        rsp_last
);
   import iwqr_pkg::*;

   // releases only ever come from a real device queue
   `IWQR_ASSERT_NOW(a_dev_legal, rsp_valid, rsp_from_device != DEV_INVALID)

   // disk releases and only disk releases go to the low ready queue
   `IWQR_ASSERT_NOW(a_low_is_disk, rsp_valid, rsp_to_low_priority == (rsp_from_device == DEV_DISK))

   // the final release of a tick is followed by a quiet cycle
   `IWQR_ASSERT_NEXT(a_last_then_gap, rsp_valid && rsp_last, !rsp_valid)

   // releases of one tick come in rising device order
   `IWQR_ASSERT_NEXT(a_dev_order, rsp_valid && !rsp_last, !rsp_valid || (rsp_from_device > $past(rsp_from_device)))

endmodule

bind io_wait_queue_release iwqr_checker u_iwqr_checker (.*);
